/* rtl/core/spimrb_pkg.sv */
// Shared types and constants for the SPI master register block.
// Holds the request/response structs, register offsets and bit positions.
// No dependencies.
package spimrb_pkg;

    // Access kind
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Register byte offsets
    localparam logic [11:0] OFS_CONTROL = 12'd0;
    localparam logic [11:0] OFS_SELECT  = 12'd4;
    localparam logic [11:0] OFS_STATUS  = 12'd8;
    localparam logic [11:0] OFS_DATA    = 12'd12;

    // Control word bits
    localparam int CW_ENABLE  = 0;
    localparam int CW_MASTER  = 1;
    localparam int CW_ERR_IE  = 2;
    localparam int CW_RXNE_IE = 3;
    localparam int CW_TXE_IE  = 4;
    localparam int CW_W       = 5;

    // Status flag bits
    localparam int SF_RXNE    = 0;
    localparam int SF_TXE     = 1;
    localparam int SF_OVERRUN = 2;
    localparam int SF_W       = 3;

    localparam int SEL_W   = 2;
    localparam int CS_W    = 4;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int ADDR_W  = 12;

    // One bus request
    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] write_data;
        logic [BYTE_W-1:0] miso_byte;
    } t_req;

    // One response
    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              irq;
        logic [CS_W-1:0]   cs_lines_n;
        logic [BYTE_W-1:0] mosi_byte;
        logic              transfer_valid;
    } t_rsp;

endpackage

/* rtl/core/spimrb_regfile.sv */
// Register state and access decode of the SPI master register block.
// Computes the response of one request and commits the state update on i_fire.
// Depends on spimrb_pkg.
module spimrb_regfile #(
    parameter int NUM_SELECTS = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  spimrb_pkg::t_req   i_req,
    output spimrb_pkg::t_rsp   o_rsp
);
    import spimrb_pkg::*;

    logic [CW_W-1:0]   r_ctrl, n_ctrl;
    logic [SEL_W-1:0]  r_sel,  n_sel;
    logic [SF_W-1:0]   r_stat, n_stat;
    logic [BYTE_W-1:0] r_rx,   n_rx;

    // Access decode, next state, interrupt level and chip selects
    always_comb begin
        n_ctrl = r_ctrl;
        n_sel  = r_sel;
        n_stat = r_stat;
        n_rx   = r_rx;
        o_rsp.read_data      = '0;
        o_rsp.mosi_byte      = '0;
        o_rsp.transfer_valid = 1'b0;
        if (i_req.command == CMD_READ) begin
            case (i_req.address)
                OFS_CONTROL: o_rsp.read_data = {{(WORD_W-CW_W){1'b0}}, r_ctrl};
                OFS_SELECT:  o_rsp.read_data = {{(WORD_W-SEL_W){1'b0}}, r_sel};
                OFS_STATUS:  o_rsp.read_data = {{(WORD_W-SF_W){1'b0}}, r_stat};
                OFS_DATA: begin
                    o_rsp.read_data = {{(WORD_W-BYTE_W){1'b0}}, r_rx};
                    n_stat[SF_RXNE] = 1'b0;
                end
                default: ;
            endcase
        end else begin
            case (i_req.address)
                OFS_CONTROL: begin
                    n_ctrl = i_req.write_data[CW_W-1:0];
                    if (i_req.write_data[CW_ENABLE]) begin
                        n_stat[SF_TXE] = 1'b1;
                    end else begin
                        n_stat = '0;
                        n_rx   = '0;
                    end
                end
                OFS_SELECT: n_sel = i_req.write_data[SEL_W-1:0];
                OFS_STATUS: begin
                    if (i_req.write_data[SF_OVERRUN]) n_stat[SF_OVERRUN] = 1'b0;
                end
                OFS_DATA: begin
                    // byte exchange only while enabled
                    if (r_ctrl[CW_ENABLE]) begin
                        if (r_stat[SF_RXNE]) n_stat[SF_OVERRUN] = 1'b1;
                        o_rsp.mosi_byte      = i_req.write_data[BYTE_W-1:0];
                        o_rsp.transfer_valid = 1'b1;
                        n_rx                 = i_req.miso_byte;
                        n_stat[SF_RXNE]      = 1'b1;
                    end
                    n_stat[SF_TXE] = 1'b1;
                end
                default: ;
            endcase
        end

        // Interrupt level after the access
        o_rsp.irq = (n_stat[SF_TXE]     & n_ctrl[CW_TXE_IE])
                  | (n_stat[SF_RXNE]    & n_ctrl[CW_RXNE_IE])
                  | (n_stat[SF_OVERRUN] & n_ctrl[CW_ERR_IE]);

        // Chip-select decode, lines past NUM_SELECTS stay high
        for (int i = 0; i < CS_W; i++) begin
            o_rsp.cs_lines_n[i] = !((i < NUM_SELECTS) && (n_sel == SEL_W'(i)));
        end
    end

    // State commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
            r_sel  <= '0;
            r_stat <= '0;
            r_rx   <= '0;
        end else if (i_fire) begin
            r_ctrl <= n_ctrl;
            r_sel  <= n_sel;
            r_stat <= n_stat;
            r_rx   <= n_rx;
        end
    end

endmodule

/* rtl/core/spi_master_register_block_unit.sv */
// An accepted request is held in the request register; its response is decoded
// combinationally and held in the response register until it is taken.
// Throughput: one request per cycle; the response register accepts a new
// result in the cycle its previous one is taken, so back-pressure stalls only.
// Reset (synchronous, active low) clears the state registers and both pipeline
// valids; the select word resets to zero, so responses show line 0 selected.
module spi_master_register_block_unit #(
    parameter int NUM_SELECTS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [11:0] i_address,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_miso_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic        o_irq,
    output logic [3:0]  o_cs_lines_n,
    output logic [7:0]  o_mosi_byte,
    output logic        o_transfer_valid
);
    import spimrb_pkg::*;

    logic r_req_valid;
    t_req r_req;
    logic r_rsp_valid;
    t_rsp r_rsp;
    t_rsp w_rsp;
    logic w_rsp_ready;
    logic w_fire;

    // Handshake chain
    assign w_rsp_ready = !r_rsp_valid || i_out_ready;
    assign w_fire      = r_req_valid && w_rsp_ready;
    assign o_in_ready  = !r_req_valid || w_rsp_ready;

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_req_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req.command    <= i_command;
            r_req.address    <= i_address;
            r_req.write_data <= i_write_data;
            r_req.miso_byte  <= i_miso_byte;
        end
    end

    spimrb_regfile #(
        .NUM_SELECTS (NUM_SELECTS)
    ) u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_rsp_ready) begin
            r_rsp_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_out_valid      = r_rsp_valid;
    assign o_read_data      = r_rsp.read_data;
    assign o_irq            = r_rsp.irq;
    assign o_cs_lines_n     = r_rsp.cs_lines_n;
    assign o_mosi_byte      = r_rsp.mosi_byte;
    assign o_transfer_valid = r_rsp.transfer_valid;

endmodule

/* rtl/core/spimrb_checker.sv */
// Port-level checks for the SPI master register block.
// Bound to spi_master_register_block_unit; uses only its ports.
// No package dependency.
module spimrb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_read_data,
    input logic        o_irq,
    input logic [3:0]  o_cs_lines_n,
    input logic [7:0]  o_mosi_byte,
    input logic        o_transfer_valid
);

    // No response shows in the cycle after reset
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid right after reset");

    // A stalled response holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data)
            && $stable(o_irq) && $stable(o_cs_lines_n) && $stable(o_mosi_byte)
            && $stable(o_transfer_valid))
        else $error("stalled response changed");

    // MOSI byte is zero unless a byte was exchanged
    a_mosi_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_transfer_valid |-> o_mosi_byte == 8'd0)
        else $error("mosi byte without transfer");

    // At most one chip select low
    a_cs_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones(~o_cs_lines_n) <= 1)
        else $error("more than one chip select active");

    // A transfer never returns read data
    a_xfer_no_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_transfer_valid |-> o_read_data == 32'd0)
        else $error("read data on a write transfer");

endmodule

bind spi_master_register_block_unit spimrb_checker u_spimrb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_read_data      (o_read_data),
    .o_irq            (o_irq),
    .o_cs_lines_n     (o_cs_lines_n),
    .o_mosi_byte      (o_mosi_byte),
    .o_transfer_valid (o_transfer_valid)
);
